// ----- rtl/wam_pkg.sv -----
package wam_pkg;

   // Register map: register i sits at byte address 4*i
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_WINDOW     = 2'd0;
   localparam logic [1:0] REG_RANGE_LOW  = 2'd1;
   localparam logic [1:0] REG_RANGE_HIGH = 2'd2;

   localparam int unsigned WINDOW_BITS = 7;
   localparam int unsigned RANGE_BITS  = 16;
   localparam int unsigned FILL_BITS   = 7;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET     = 7'd64;
   localparam logic [RANGE_BITS-1:0]  RANGE_LOW_RESET  = 16'h0000;
   localparam logic [RANGE_BITS-1:0]  RANGE_HIGH_RESET = 16'h7fff;

   // Write strobes, write data and the current window value for the datapath
   typedef struct packed {
      logic                   window_we;
      logic                   low_we;
      logic                   high_we;
      logic [RANGE_BITS-1:0]  wdata;
      logic [WINDOW_BITS-1:0] window;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic write;
      logic sum_step;
      logic div_init;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sum_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/wam_ram.sv -----
module wam_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/wam_csr.sv -----
module wam_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wam_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output wam_pkg::cfg_type                    cfg
);

   logic [wam_pkg::WINDOW_BITS-1:0] window_ff, window_in;
   logic [wam_pkg::RANGE_BITS-1:0]  range_low_ff, range_low_in;
   logic [wam_pkg::RANGE_BITS-1:0]  range_high_ff, range_high_in;
   logic                            wr_en;
   logic [1:0]                      reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      window_in     = window_ff;
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      cfg           = '0;
      cfg.wdata     = csr_pwdata[wam_pkg::RANGE_BITS-1:0];
      cfg.window    = window_ff;
      if (wr_en) begin
         unique case (reg_idx)
            wam_pkg::REG_WINDOW: begin
               window_in     = csr_pwdata[wam_pkg::WINDOW_BITS-1:0];
               cfg.window_we = 1'b1;
            end
            wam_pkg::REG_RANGE_LOW: begin
               range_low_in = csr_pwdata[wam_pkg::RANGE_BITS-1:0];
               cfg.low_we   = 1'b1;
            end
            wam_pkg::REG_RANGE_HIGH: begin
               range_high_in = csr_pwdata[wam_pkg::RANGE_BITS-1:0];
               cfg.high_we   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         wam_pkg::REG_WINDOW:     csr_prdata = 32'(window_ff);
         wam_pkg::REG_RANGE_LOW:  csr_prdata = 32'($signed(range_low_ff));
         wam_pkg::REG_RANGE_HIGH: csr_prdata = 32'($signed(range_high_ff));
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= wam_pkg::WINDOW_RESET;
         range_low_ff  <= wam_pkg::RANGE_LOW_RESET;
         range_high_ff <= wam_pkg::RANGE_HIGH_RESET;
      end else begin
         window_ff     <= window_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

endmodule

// ----- rtl/wam_ctrl.sv -----
module wam_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wam_pkg::status_type status,
   output wam_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WRITE = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            if (status.sum_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.sum_step = 1'b1;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FIN: begin
            // hold the result until the output register is free
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/wam_dp.sv -----
module wam_dp #(
   parameter int unsigned MAX_WINDOW  = 64,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wam_pkg::cfg_type                      cfg,
   input  wam_pkg::cmd_type                      cmd,
   output wam_pkg::status_type                   status,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_average,
   output logic signed [SAMPLE_BITS-1:0]         rsp_lowest,
   output logic signed [SAMPLE_BITS-1:0]         rsp_highest,
   output logic [wam_pkg::FILL_BITS-1:0]         rsp_fill
);

   localparam int unsigned IDX_BITS  = $clog2(MAX_WINDOW);
   localparam int unsigned CNT_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int unsigned PTR_BITS  = CNT_BITS + 1;
   localparam int unsigned EXT_BITS  =
      (SAMPLE_BITS > wam_pkg::RANGE_BITS) ? SAMPLE_BITS : wam_pkg::RANGE_BITS;
   localparam int unsigned SUM_BITS  = SAMPLE_BITS + CNT_BITS;
   localparam int unsigned DCNT_BITS = $clog2(SUM_BITS + 1);
   localparam int unsigned WIDE_BITS =
      (CNT_BITS > wam_pkg::WINDOW_BITS) ? CNT_BITS : wam_pkg::WINDOW_BITS;
   localparam int unsigned FWIDE_BITS =
      (CNT_BITS > wam_pkg::FILL_BITS) ? CNT_BITS : wam_pkg::FILL_BITS;

   // Clamp a window register value to 1..MAX_WINDOW
   function automatic logic [CNT_BITS-1:0] eff_window(
      input logic [wam_pkg::WINDOW_BITS-1:0] w
   );
      logic [WIDE_BITS-1:0] wx;
      wx = WIDE_BITS'(w);
      if (wx == '0) begin
         return CNT_BITS'(1);
      end else if (wx > WIDE_BITS'(MAX_WINDOW)) begin
         return CNT_BITS'(MAX_WINDOW);
      end else begin
         return wx[CNT_BITS-1:0];
      end
   endfunction

   // Ring slot a advanced by b, b at most MAX_WINDOW
   function automatic logic [IDX_BITS-1:0] wrap_add(
      input logic [IDX_BITS-1:0] a,
      input logic [CNT_BITS-1:0] b
   );
      logic [PTR_BITS-1:0] s;
      s = PTR_BITS'(a) + PTR_BITS'(b);
      if (s >= PTR_BITS'(MAX_WINDOW)) begin
         s = s - PTR_BITS'(MAX_WINDOW);
      end
      return s[IDX_BITS-1:0];
   endfunction

   logic [IDX_BITS-1:0]              oldest_ff, oldest_in;
   logic [CNT_BITS-1:0]              count_ff, count_in;
   logic signed [EXT_BITS-1:0]       min_ff, min_in;
   logic signed [EXT_BITS-1:0]       max_ff, max_in;
   logic signed [SAMPLE_BITS-1:0]    sample_ff, sample_in;
   logic [IDX_BITS-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]              rd_left_ff, rd_left_in;
   logic                             pend_ff, pend_in;
   logic signed [SUM_BITS-1:0]       acc_ff, acc_in;
   logic [CNT_BITS-1:0]              rem_ff, rem_in;
   logic [SUM_BITS-1:0]              quo_ff, quo_in;
   logic                             neg_ff, neg_in;
   logic [DCNT_BITS-1:0]             dcnt_ff, dcnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]    avg_ff, avg_in;
   logic signed [SAMPLE_BITS-1:0]    low_ff, low_in;
   logic signed [SAMPLE_BITS-1:0]    high_ff, high_in;
   logic [wam_pkg::FILL_BITS-1:0]    fill_ff, fill_in;

   logic                             ram_we;
   logic [IDX_BITS-1:0]              ram_waddr;
   logic [SAMPLE_BITS-1:0]           ram_rdata_raw;
   logic signed [SAMPLE_BITS-1:0]    ram_rdata;
   logic [CNT_BITS-1:0]              win_now;
   logic [CNT_BITS-1:0]              win_new;
   logic signed [EXT_BITS-1:0]       sample_ext;
   logic [PTR_BITS-1:0]              trial;
   logic [SUM_BITS-1:0]              avg_full;
   logic [FWIDE_BITS-1:0]            fill_wide;

   wam_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (sample_ff),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata  = $signed(ram_rdata_raw);
   assign win_now    = eff_window(cfg.window);
   assign win_new    = eff_window(cfg.wdata[wam_pkg::WINDOW_BITS-1:0]);
   assign sample_ext = EXT_BITS'(sample_ff);
   assign ram_waddr  = wrap_add(oldest_ff, count_ff);
   assign trial      = {rem_ff, quo_ff[SUM_BITS-1]};
   assign avg_full   = neg_ff ? (SUM_BITS'(0) - quo_ff) : quo_ff;
   assign fill_wide  = FWIDE_BITS'(count_ff);

   assign status.sum_done = (rd_left_ff == '0) && !pend_ff;
   assign status.div_done = (dcnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sample_in    = sample_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_left_in   = rd_left_ff;
      pend_in      = pend_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      avg_in       = avg_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      fill_in      = fill_ff;
      ram_we       = 1'b0;

      // Shrinking the window drops the oldest samples
      if (cfg.window_we && (count_ff > win_new)) begin
         oldest_in = wrap_add(oldest_ff, count_ff - win_new);
         count_in  = win_new;
      end
      if (cfg.low_we) begin
         max_in = EXT_BITS'($signed(cfg.wdata));
      end
      if (cfg.high_we) begin
         min_in = EXT_BITS'($signed(cfg.wdata));
      end

      if (cmd.accept) begin
         sample_in = req_sample;
         // Ring full: make room for the new sample
         if (count_ff >= win_now) begin
            oldest_in = wrap_add(oldest_ff, count_ff - (win_now - CNT_BITS'(1)));
            count_in  = win_now - CNT_BITS'(1);
         end
      end

      if (cmd.write) begin
         ram_we     = 1'b1;
         count_in   = count_ff + CNT_BITS'(1);
         rd_ptr_in  = oldest_ff;
         rd_left_in = count_ff + CNT_BITS'(1);
         pend_in    = 1'b0;
         acc_in     = '0;
         if (sample_ext > max_ff) begin
            max_in = sample_ext;
         end
         if (sample_ext < min_ff) begin
            min_in = sample_ext;
         end
      end

      if (cmd.sum_step) begin
         if (rd_left_ff != '0) begin
            rd_ptr_in  = wrap_add(rd_ptr_ff, CNT_BITS'(1));
            rd_left_in = rd_left_ff - CNT_BITS'(1);
            pend_in    = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            acc_in = acc_ff + SUM_BITS'(ram_rdata);
         end
      end

      if (cmd.div_init) begin
         neg_in  = acc_ff[SUM_BITS-1];
         quo_in  = acc_ff[SUM_BITS-1] ? (SUM_BITS'(0) - SUM_BITS'(acc_ff))
                                      : SUM_BITS'(acc_ff);
         rem_in  = '0;
         dcnt_in = DCNT_BITS'(SUM_BITS);
      end

      // Restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         if (trial >= PTR_BITS'(count_ff)) begin
            rem_in = CNT_BITS'(trial - PTR_BITS'(count_ff));
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - DCNT_BITS'(1);
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         avg_in       = $signed(avg_full[SAMPLE_BITS-1:0]);
         low_in       = min_ff[SAMPLE_BITS-1:0];
         high_in      = max_ff[SAMPLE_BITS-1:0];
         fill_in      = fill_wide[wam_pkg::FILL_BITS-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         count_ff     <= '0;
         min_ff       <= EXT_BITS'($signed(wam_pkg::RANGE_HIGH_RESET));
         max_ff       <= EXT_BITS'($signed(wam_pkg::RANGE_LOW_RESET));
         rd_left_ff   <= '0;
         pend_ff      <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rd_left_ff   <= rd_left_in;
         pend_ff      <= pend_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      rd_ptr_ff <= rd_ptr_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      avg_ff    <= avg_in;
      low_ff    <= low_in;
      high_ff   <= high_in;
      fill_ff   <= fill_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = avg_ff;
   assign rsp_lowest  = low_ff;
   assign rsp_highest = high_ff;
   assign rsp_fill    = fill_ff;

endmodule

// ----- rtl/windowed_average_min_max.sv -----
// Windowed average with running minimum and maximum.
// req channel: one signed Q8.8 sample per transaction (valid/ready).
// rsp channel: one transaction per sample carrying the truncated average of
// the most recent window_size samples, the running minimum and maximum since
// reset (or since the range register was last written) and the fill count.
// csr port: APB-style, pready always high; window_size at 0x0, range_low at
// 0x4 (reloads the maximum), range_high at 0x8 (reloads the minimum).
// Each sample is accepted, written to the ring, summed over the window, divided
// by the fill count and loaded into the output register; the next sample can be
// taken in the cycle after the result is loaded. One sample is processed at a
// time; the ring is read one entry per cycle through its single read port and
// the quotient is produced one bit per cycle. req_ready is high whenever no
// sample is in work, even while a finished result waits on rsp_ready.
// A stalled receiver holds the result; the next sample then waits before its
// result is loaded. Reset empties the window and loads the extremes from the
// register reset values; ring contents need no clearing.
module windowed_average_min_max #(
   parameter int unsigned MAX_WINDOW  = 64,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_average,
   output logic signed [SAMPLE_BITS-1:0]       rsp_lowest,
   output logic signed [SAMPLE_BITS-1:0]       rsp_highest,
   output logic [wam_pkg::FILL_BITS-1:0]       rsp_fill,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wam_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   wam_pkg::cfg_type    cfg;
   wam_pkg::cmd_type    cmd;
   wam_pkg::status_type status;

   wam_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wam_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_average (rsp_average),
      .rsp_lowest  (rsp_lowest),
      .rsp_highest (rsp_highest),
      .rsp_fill    (rsp_fill)
   );

endmodule

// ----- test/window_stats_checker.sv -----
`timescale 1ns / 100ps

module window_stats_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [15:0]                  req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [15:0]                  rsp_average,
   input  logic signed [15:0]                  rsp_lowest,
   input  logic signed [15:0]                  rsp_highest,
   input  logic [wam_pkg::FILL_BITS-1:0]       rsp_fill,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wam_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   input  logic [31:0]                         csr_prdata,
   input  logic                                csr_pready,
   output int                                  mismatch_count,
   output int                                  stats_outstanding
);

   localparam int unsigned RING_DEPTH = 64;
   localparam int unsigned DUE_DEPTH  = 8;

   typedef struct packed {
      logic signed [15:0]            average;
      logic signed [15:0]            lowest;
      logic signed [15:0]            highest;
      logic [wam_pkg::FILL_BITS-1:0] fill;
   } window_stats_type;

   logic signed [15:0]                    ring [RING_DEPTH];
   logic [5:0]                            oldest_slot;
   int unsigned                           stored_count;
   logic [wam_pkg::WINDOW_BITS-1:0]       window_reg;
   logic signed [wam_pkg::RANGE_BITS-1:0] range_low_reg;
   logic signed [wam_pkg::RANGE_BITS-1:0] range_high_reg;
   logic signed [15:0]                    min_seen;
   logic signed [15:0]                    max_seen;
   window_stats_type                      stats_due [DUE_DEPTH];
   logic [2:0]                            due_head;
   logic [2:0]                            due_tail;
   int unsigned                           due_count;

   // Window value 0 behaves as 1, anything past the ring depth as the full ring
   function automatic int unsigned span(input logic [wam_pkg::WINDOW_BITS-1:0] w);
      if (w == 0)
         return 1;
      if (w > RING_DEPTH)
         return RING_DEPTH;
      return 32'(w);
   endfunction

   task automatic drop_to(input int unsigned limit);
      while (stored_count > limit) begin
         oldest_slot = oldest_slot + 6'd1;
         stored_count--;
      end
   endtask

   task automatic flag(input string what, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
   endtask

   task automatic absorb_sample(input logic signed [15:0] s);
      int               sum;
      int unsigned      limit;
      window_stats_type stats;
      limit = span(window_reg);
      drop_to(limit - 1);
      ring[6'(oldest_slot + stored_count)] = s;
      stored_count++;
      if (s > max_seen)
         max_seen = s;
      if (s < min_seen)
         min_seen = s;
      sum = 0;
      for (int unsigned i = 0; i < stored_count; i++)
         sum += ring[6'(oldest_slot + i)];
      stats.average = 16'(sum / int'(stored_count));
      stats.lowest  = min_seen;
      stats.highest = max_seen;
      stats.fill    = wam_pkg::FILL_BITS'(stored_count);
      if (due_count == DUE_DEPTH) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("too many results outstanding at sample %h", s);
      end else begin
         stats_due[due_tail] = stats;
         due_tail = due_tail + 3'd1;
         due_count++;
      end
   endtask

   always @(posedge clock) begin
      window_stats_type want;
      if (reset) begin
         mismatch_count = 0;
         oldest_slot    = '0;
         stored_count   = 0;
         window_reg     = wam_pkg::WINDOW_RESET;
         range_low_reg  = wam_pkg::RANGE_LOW_RESET;
         range_high_reg = wam_pkg::RANGE_HIGH_RESET;
         min_seen       = range_high_reg;
         max_seen       = range_low_reg;
         due_head       = '0;
         due_tail       = '0;
         due_count      = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  wam_pkg::REG_WINDOW: begin
                     window_reg = csr_pwdata[wam_pkg::WINDOW_BITS-1:0];
                     drop_to(span(window_reg));
                  end
                  wam_pkg::REG_RANGE_LOW: begin
                     range_low_reg = csr_pwdata[wam_pkg::RANGE_BITS-1:0];
                     max_seen = range_low_reg;
                  end
                  wam_pkg::REG_RANGE_HIGH: begin
                     range_high_reg = csr_pwdata[wam_pkg::RANGE_BITS-1:0];
                     min_seen = range_high_reg;
                  end
                  default: ;
               endcase
            end else begin
               case (csr_paddr[3:2])
                  wam_pkg::REG_WINDOW:
                     flag("window_size read", 16'(window_reg),
                          16'(csr_prdata[wam_pkg::WINDOW_BITS-1:0]));
                  wam_pkg::REG_RANGE_LOW:
                     flag("range_low read", range_low_reg,
                          csr_prdata[wam_pkg::RANGE_BITS-1:0]);
                  wam_pkg::REG_RANGE_HIGH:
                     flag("range_high read", range_high_reg,
                          csr_prdata[wam_pkg::RANGE_BITS-1:0]);
                  default: ;
               endcase
            end
         end
         // Retire the result before queuing a sample taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (due_count == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected transaction: average %h lowest %h highest %h fill %h",
                           rsp_average, rsp_lowest, rsp_highest, rsp_fill);
            end else begin
               want = stats_due[due_head];
               due_head = due_head + 3'd1;
               due_count--;
               flag("average", want.average, rsp_average);
               flag("lowest", want.lowest, rsp_lowest);
               flag("highest", want.highest, rsp_highest);
               flag("fill", 16'(want.fill), 16'(rsp_fill));
            end
         end
         if (req_valid && req_ready)
            absorb_sample(req_sample);
      end
      stats_outstanding = int'(due_count);
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int SAMPLE_TARGET = 950;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 120;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [15:0]                  req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [15:0]                  rsp_average;
   logic signed [15:0]                  rsp_lowest;
   logic signed [15:0]                  rsp_highest;
   logic [wam_pkg::FILL_BITS-1:0]       rsp_fill;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [wam_pkg::CSR_ADDR_BITS-1:0]   csr_paddr = '0;
   logic [31:0]                         csr_pwdata = '0;
   logic [31:0]                         csr_prdata;
   logic                                csr_pready;

   int mismatch_count;
   int stats_outstanding;
   int samples_sent = 0;
   int quiet_cycles = 0;
   bit calm_req = 1'b0;
   bit calm_rsp = 1'b0;

   always #1 clock = ~clock;

   windowed_average_min_max u_top (.*);

   window_stats_checker u_check (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Hold valid from the last transaction when the next one follows with no gap
   task automatic offer_sample(input logic [15:0] value);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      samples_sent++;
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (stats_outstanding != 0)
         @(negedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [1:0] idx,
                             input logic [31:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = is_write;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = calm_rsp ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int                              phase_len;
      logic [15:0]                     value;
      logic [wam_pkg::WINDOW_BITS-1:0] win;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      csr_access(1'b0, wam_pkg::REG_WINDOW, '0);
      csr_access(1'b0, wam_pkg::REG_RANGE_LOW, '0);
      csr_access(1'b0, wam_pkg::REG_RANGE_HIGH, '0);
      offer_sample(16'h7fff);
      offer_sample(16'h8000);
      offer_sample(16'h0000);
      offer_sample(16'hffff);
      offer_sample(16'h0001);
      offer_sample(16'h5555);
      offer_sample(16'haaaa);

      // Window of zero acts as one and drops all but the newest sample
      settle();
      csr_access(1'b1, wam_pkg::REG_WINDOW, 32'd0);
      offer_sample(16'h0003);
      offer_sample(16'hfffb);

      // Oversized window clamps to the full ring
      settle();
      csr_access(1'b1, wam_pkg::REG_WINDOW, 32'd127);
      offer_sample(16'hfffd);
      offer_sample(16'hfffd);
      offer_sample(16'h0002);

      // Bounds of -100 and 100 so only samples outside them move the extremes, then overflow the window
      settle();
      csr_access(1'b1, wam_pkg::REG_WINDOW, 32'd3);
      csr_access(1'b1, wam_pkg::REG_RANGE_LOW, 32'h0064);
      csr_access(1'b1, wam_pkg::REG_RANGE_HIGH, 32'hff9c);
      offer_sample(16'h0000);
      offer_sample(16'h0100);
      offer_sample(16'hff00);
      offer_sample(16'h7fff);
      offer_sample(16'h8000);
      offer_sample(16'h0001);

      settle();
      csr_access(1'b1, wam_pkg::REG_WINDOW, 32'd2);
      csr_access(1'b1, REG_UNUSED, $urandom);
      csr_access(1'b0, wam_pkg::REG_WINDOW, '0);
      csr_access(1'b0, wam_pkg::REG_RANGE_LOW, '0);
      csr_access(1'b0, wam_pkg::REG_RANGE_HIGH, '0);
      offer_sample(16'h1234);
      offer_sample(16'hedcc);

      settle();
      csr_access(1'b1, wam_pkg::REG_RANGE_HIGH, 32'h8000);
      csr_access(1'b1, wam_pkg::REG_RANGE_LOW, 32'h7fff);
      offer_sample(16'h8000);
      offer_sample(16'h7fff);

      while (samples_sent < SAMPLE_TARGET) begin
         settle();
         calm_req = ($urandom_range(0, 3) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0:       win = '0;
               1:       win = 7'd1;
               2:       win = 7'd64;
               3:       win = 7'd127;
               4:       win = 7'($urandom_range(65, 126));
               5:       win = 7'($urandom);
               6, 7:    win = 7'($urandom_range(2, 8));
               default: win = 7'($urandom_range(1, 64));
            endcase
            csr_access(1'b1, wam_pkg::REG_WINDOW, 32'(win));
         end
         for (int k = 0; k < 2; k++) begin
            if ($urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 5))
                  0:       value = 16'h8000;
                  1:       value = 16'h7fff;
                  2:       value = 16'h0000;
                  default: value = 16'($urandom);
               endcase
               csr_access(1'b1, (k == 0) ? wam_pkg::REG_RANGE_LOW : wam_pkg::REG_RANGE_HIGH,
                          32'(value));
            end
         end
         if ($urandom_range(0, 7) == 0)
            csr_access(1'b1, REG_UNUSED, $urandom);
         if ($urandom_range(0, 3) == 0)
            csr_access(1'b0, 2'($urandom_range(0, 2)), '0);
         phase_len = $urandom_range(15, 80);
         if (phase_len > SAMPLE_TARGET - samples_sent)
            phase_len = SAMPLE_TARGET - samples_sent;
         repeat (phase_len) begin
            case ($urandom_range(0, 9))
               0:       value = 16'h7fff;
               1:       value = 16'h8000;
               2:       value = 16'(-$urandom_range(0, 3));
               3, 4:    value = 16'(int'($urandom_range(0, 512)) - 256);
               default: value = 16'($urandom);
            endcase
            offer_sample(value);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && stats_outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/wam_pkg.sv
rtl/wam_ram.sv
rtl/wam_csr.sv
rtl/wam_ctrl.sv
rtl/wam_dp.sv
rtl/windowed_average_min_max.sv
test/window_stats_checker.sv
test/testbench.sv
